[sv/mcw_pkg.sv]
`timescale 1ns / 1ps
package mcw_pkg;
  localparam int unsigned MaxText  = 4096;
  localparam int unsigned Alphabet = 256;
  localparam int unsigned PosW     = $clog2(MaxText);
  localparam int unsigned CntW     = PosW + 1;
  localparam int unsigned SymW     = $clog2(Alphabet);
  localparam int unsigned QDepth   = 2;

  typedef struct packed {
    logic       mode;
    logic [7:0] symbol;
    logic       last;
  } in_word_t;

  typedef struct packed {
    logic            found;
    logic [PosW-1:0] window_start;
    logic [CntW-1:0] window_length;
    logic            overflow;
  } out_word_t;

  // Classified word handed from front to back.
  typedef struct packed {
    logic            is_text;
    logic [SymW-1:0] sym;
    logic            last;
  } cmd_t;
endpackage

[sv/minimum_covering_window.sv]
`timescale 1ns / 1ps
// Channel | Direction | Handshake               | Word
// in      | input     | in_valid_i / in_ready_o  | mcw_pkg::in_word_t
// out     | output    | out_valid_o / out_ready_i| mcw_pkg::out_word_t
//
// A pattern word reads its needed count in the back end, then writes it back.
// A text word reads and updates its seen count; each byte the window start moves past
// adds a read and check; a covered pattern adds edge check, stop check, best update.
// Pace is set by the single histogram read port; a new word waits until the last is done.
// After reset and after each result, a clearing pass over all 256 entries wipes the
// histograms; words queue in the two-entry front queue meanwhile.
// A pending result stalls the back end until it is taken.
module minimum_covering_window (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mcw_pkg::in_word_t  in_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output mcw_pkg::out_word_t out_data_o,
  output logic               out_valid_o,
  input  logic               out_ready_i
);
  import mcw_pkg::*;

  cmd_t cmd;
  logic cmd_valid, cmd_ready;

  // Accept and classify words; queue them for the back end.
  mcw_front u_front (
    .clk_i, .rst_ni, .in_data_i, .in_valid_i, .in_ready_o,
    .cmd_o(cmd), .cmd_valid_o(cmd_valid), .cmd_ready_i(cmd_ready)
  );

  // Run the histogram and window logic.
  mcw_back u_back (
    .clk_i, .rst_ni, .cmd_i(cmd), .cmd_valid_i(cmd_valid), .cmd_ready_o(cmd_ready),
    .out_data_o, .out_valid_o, .out_ready_i
  );
endmodule

[sv/mcw_front.sv]
`timescale 1ns / 1ps
module mcw_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mcw_pkg::in_word_t in_data_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output mcw_pkg::cmd_t     cmd_o,
  output logic              cmd_valid_o,
  input  logic              cmd_ready_i
);
  import mcw_pkg::*;

  cmd_t              q_mem [QDepth];
  logic              wr_q, wr_d, rd_q, rd_d;
  logic [1:0]        cnt_q, cnt_d;
  logic              push, pop;
  cmd_t              c;

  always_comb begin
    c.is_text = in_data_i.mode;
    c.sym     = in_data_i.symbol[SymW-1:0];
    c.last    = in_data_i.last & in_data_i.mode;
  end

  assign in_ready_o  = (cnt_q != 2'(QDepth));
  assign push        = in_valid_i & in_ready_o;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign pop         = cmd_valid_o & cmd_ready_i;
  assign cmd_o       = q_mem[rd_q];
  assign wr_d        = push ? ~wr_q : wr_q;
  assign rd_d        = pop ? ~rd_q : rd_q;
  assign cnt_d       = cnt_q + {1'b0, push} - {1'b0, pop};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) q_mem[wr_q] <= c;
  end
endmodule

[sv/mcw_back.sv]
`timescale 1ns / 1ps
module mcw_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mcw_pkg::cmd_t      cmd_i,
  input  logic               cmd_valid_i,
  output logic               cmd_ready_o,
  output mcw_pkg::out_word_t out_data_o,
  output logic               out_valid_o,
  input  logic               out_ready_i
);
  import mcw_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_PAT, S_TXT, S_SHRINK_RD, S_SHRINK, S_BEST, S_DONE
  } state_e;

  logic [CntW-1:0] need_mem [Alphabet];
  logic [CntW-1:0] seen_mem [Alphabet];
  logic [SymW-1:0] text_mem [MaxText];

  state_e          state_q;
  logic [SymW-1:0] clr_q;
  logic [CntW-1:0] plen_q, match_q, tpos_q, best_len_q;
  logic [PosW-1:0] left_q, best_start_q, pos_q;
  logic            ovf_q, last_q, best_v_q;
  logic [SymW-1:0] sym_q;
  logic [CntW-1:0] need_rd_q, seen_rd_q;
  logic [SymW-1:0] buf_rd_q;
  logic [CntW-1:0] cur_len;
  logic [CntW-1:0] match_inc;
  logic [SymW-1:0] rd_addr;

  assign cmd_ready_o = (state_q == S_IDLE);
  assign cur_len = {1'b0, pos_q} - {1'b0, left_q} + CntW'(1);
  // Seen count after increment still within need: one more matched.
  assign match_inc = ((seen_rd_q + CntW'(1)) <= need_rd_q) ? match_q + CntW'(1) : match_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      clr_q        <= '0;
      plen_q       <= '0;
      match_q      <= '0;
      tpos_q       <= '0;
      left_q       <= '0;
      best_start_q <= '0;
      best_len_q   <= '0;
      best_v_q     <= 1'b0;
      ovf_q        <= 1'b0;
      last_q       <= 1'b0;
      out_valid_o  <= 1'b0;
      sym_q        <= '0;
      pos_q        <= '0;
      out_data_o   <= '0;
    end else begin
      case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + SymW'(1);
          if (clr_q == SymW'(Alphabet - 1)) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (cmd_valid_i) begin
            sym_q  <= cmd_i.sym;
            last_q <= cmd_i.last;
            if (!cmd_i.is_text) begin
              if (plen_q == CntW'(MaxText)) ovf_q <= 1'b1;
              else begin
                plen_q  <= plen_q + CntW'(1);
                state_q <= S_PAT;
              end
            end else if (tpos_q == CntW'(MaxText)) begin
              ovf_q <= 1'b1;
              state_q <= cmd_i.last ? S_DONE : S_IDLE;
            end else begin
              pos_q   <= tpos_q[PosW-1:0];
              tpos_q  <= tpos_q + CntW'(1);
              state_q <= S_TXT;
            end
          end
        end
        S_PAT: begin
          state_q <= S_IDLE;
        end
        S_TXT: begin
          match_q <= match_inc;
          if (plen_q != '0 && match_inc == plen_q) state_q <= S_SHRINK_RD;
          else state_q <= last_q ? S_DONE : S_IDLE;
        end
        S_SHRINK_RD: begin
          if (left_q < pos_q) state_q <= S_SHRINK;
          else state_q <= S_BEST;
        end
        S_SHRINK: begin
          if (seen_rd_q > need_rd_q) begin
            left_q  <= left_q + PosW'(1);
            state_q <= S_SHRINK_RD;
          end else if (need_rd_q == '0) begin
            left_q  <= left_q + PosW'(1);
            state_q <= S_SHRINK_RD;
          end else begin
            state_q <= S_BEST;
          end
        end
        S_BEST: begin
          if (!best_v_q || cur_len < best_len_q) begin
            best_v_q     <= 1'b1;
            best_len_q   <= cur_len;
            best_start_q <= left_q;
          end
          state_q <= last_q ? S_DONE : S_IDLE;
        end
        S_DONE: begin
          if (!out_valid_o) begin
            out_valid_o              <= 1'b1;
            out_data_o.found         <= best_v_q;
            out_data_o.window_start  <= best_v_q ? best_start_q : '0;
            out_data_o.window_length <= best_v_q ? best_len_q : '0;
            out_data_o.overflow      <= ovf_q;
          end else if (out_ready_i) begin
            out_valid_o <= 1'b0;
            plen_q   <= '0;
            match_q  <= '0;
            tpos_q   <= '0;
            left_q   <= '0;
            best_v_q <= 1'b0;
            ovf_q    <= 1'b0;
            clr_q    <= '0;
            state_q  <= S_CLEAR;
          end
        end
        default: state_q <= S_CLEAR;
      endcase
    end
  end

  // Table ports: one read per table, one write per table each cycle.
  always_comb begin
    rd_addr = cmd_i.sym;
    if (state_q == S_SHRINK_RD) rd_addr = buf_rd_q;
  end

  // Buffer read of the left edge; left moves only in S_SHRINK so read there.
  always_ff @(posedge clk_i) begin
    if (state_q == S_SHRINK && (seen_rd_q > need_rd_q || need_rd_q == '0))
      buf_rd_q <= text_mem[left_q + PosW'(1)];
    else
      buf_rd_q <= text_mem[left_q];
    if (state_q == S_IDLE && cmd_valid_i && cmd_i.is_text && tpos_q != CntW'(MaxText))
      text_mem[tpos_q[PosW-1:0]] <= cmd_i.sym;
  end

  always_ff @(posedge clk_i) begin
    need_rd_q <= need_mem[rd_addr];
    seen_rd_q <= seen_mem[rd_addr];
    if (state_q == S_CLEAR) begin
      need_mem[clr_q] <= '0;
      seen_mem[clr_q] <= '0;
    end else if (state_q == S_PAT) begin
      need_mem[sym_q] <= need_rd_q + CntW'(1);
    end
    if (state_q == S_TXT)
      seen_mem[sym_q] <= seen_rd_q + CntW'(1);
    else if (state_q == S_SHRINK && seen_rd_q > need_rd_q)
      seen_mem[buf_rd_q] <= seen_rd_q - CntW'(1);
  end
endmodule
